// ===== sv/fnic_pkg.sv =====
// Shared types, command codes and range constants for the float/normalized-integer converter.
// Used by every stage module and by the top level; depends on nothing.
`default_nettype none

package fnic_pkg;

	localparam logic [3:0] CMD_F2U8  = 4'd0;
	localparam logic [3:0] CMD_F2U16 = 4'd1;
	localparam logic [3:0] CMD_F2U32 = 4'd2;
	localparam logic [3:0] CMD_F2S8  = 4'd3;
	localparam logic [3:0] CMD_F2S16 = 4'd4;
	localparam logic [3:0] CMD_F2S32 = 4'd5;
	localparam logic [3:0] CMD_U2F8  = 4'd6;
	localparam logic [3:0] CMD_U2F16 = 4'd7;
	localparam logic [3:0] CMD_U2F32 = 4'd8;
	localparam logic [3:0] CMD_S2F8  = 4'd9;
	localparam logic [3:0] CMD_S2F16 = 4'd10;
	localparam logic [3:0] CMD_S2F32 = 4'd11;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_F2N  = 2'd1;
	localparam logic [1:0] KIND_N2F  = 2'd2;

	localparam logic [1:0] NSEL_8  = 2'd0;
	localparam logic [1:0] NSEL_16 = 2'd1;
	localparam logic [1:0] NSEL_32 = 2'd2;

	localparam logic [40:0] CAP_MAG = 41'h100_0000_0000;
	localparam logic [31:0] ONE_SINGLE = 32'h3F80_0000;

	localparam logic [0:0] REG_ROUND_BIAS = 1'b0;

	typedef struct packed {
		logic [1:0]        kind;
		logic              is_snorm;
		logic              neg;
		logic              nan;
		logic              inf;
		logic [1:0]        nsel;
		logic [55:0]       prod;
		logic signed [8:0] expo;
		logic              sign;
		logic              one;
		logic              zero;
		logic [63:0]       src;
		logic [31:0]       lzsrc;
		logic [7:0]        ebase;
	} s1_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        is_snorm;
		logic        neg;
		logic        nan;
		logic [1:0]  nsel;
		logic [40:0] ip;
		logic        half;
		logic        sign;
		logic        one;
		logic        zero;
		logic [24:0] nsig;
		logic        nsticky;
		logic [7:0]  nexp;
	} s2_t;

	function automatic logic [31:0] lim_pos(input logic is_snorm, input logic [1:0] nsel);
		logic [31:0] v;
		case (nsel)
			NSEL_8:  v = is_snorm ? 32'h0000_007F : 32'h0000_00FF;
			NSEL_16: v = is_snorm ? 32'h0000_7FFF : 32'h0000_FFFF;
			default: v = is_snorm ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] lim_neg(input logic [1:0] nsel);
		logic [31:0] v;
		case (nsel)
			NSEL_8:  v = 32'h0000_0080;
			NSEL_16: v = 32'h0000_8000;
			default: v = 32'h8000_0000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fnic_decode.sv =====
// First stage: command decode, exact scaling product by shift and subtract (shift
// only for negative SNORM), and operand preparation for the integer-to-single path. Depends on fnic_pkg.
`default_nettype none

module fnic_decode (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [3:0]   command,
	input  wire logic [31:0]  operand,
	output fnic_pkg::s1_t     st_s1
);
	import fnic_pkg::*;

	s1_t         d;
	logic [7:0]  e_field;
	logic [22:0] frac;
	logic [55:0] mw;
	logic [55:0] pm;
	logic [5:0]  sh;
	logic [31:0] msk;
	logic [31:0] v;
	logic [31:0] a;
	logic        pos;
	logic        hbit;

	always_comb begin
		e_field = operand[30:23];
		frac = operand[22:0];
		d = '0;
		case (command)
			CMD_F2U8, CMD_F2S8, CMD_U2F8, CMD_S2F8: d.nsel = NSEL_8;
			CMD_F2U16, CMD_F2S16, CMD_U2F16, CMD_S2F16: d.nsel = NSEL_16;
			default: d.nsel = NSEL_32;
		endcase
		case (command) inside
			[CMD_F2U8:CMD_F2S32]: d.kind = KIND_F2N;
			[CMD_U2F8:CMD_S2F32]: d.kind = KIND_N2F;
			default: d.kind = KIND_NONE;
		endcase
		d.is_snorm = (command inside {[CMD_F2S8:CMD_F2S32], [CMD_S2F8:CMD_S2F32]});

		d.neg = operand[31] && (operand[30:0] != 31'd0);
		d.nan = (e_field == 8'hFF) && (frac != 23'd0);
		d.inf = (e_field == 8'hFF) && (frac == 23'd0);
		d.expo = (e_field != 8'd0) ? ($signed({1'b0, e_field}) - 9'sd150) : -9'sd149;
		mw = {32'd0, (e_field != 8'd0), frac};
		case (d.nsel)
			NSEL_8:  sh = d.is_snorm ? 6'd7 : 6'd8;
			NSEL_16: sh = d.is_snorm ? 6'd15 : 6'd16;
			default: sh = d.is_snorm ? 6'd31 : 6'd32;
		endcase
		pm = mw << sh;
		d.prod = (d.is_snorm && d.neg) ? pm : (pm - mw);

		case (d.nsel)
			NSEL_8:  msk = 32'h0000_00FF;
			NSEL_16: msk = 32'h0000_FFFF;
			default: msk = 32'hFFFF_FFFF;
		endcase
		v = operand & msk;
		case (d.nsel)
			NSEL_8:  hbit = v[7];
			NSEL_16: hbit = v[15];
			default: hbit = v[31];
		endcase
		pos = !(d.is_snorm && hbit);
		a = pos ? v : ((32'd0 - v) & msk);
		d.sign = !pos;
		d.zero = (a == 32'd0);
		d.one = pos && (a == (d.is_snorm ? (msk >> 1) : msk));
		if (pos) begin
			d.ebase = 8'd126;
			case ({d.is_snorm, d.nsel})
				{1'b0, NSEL_8}: begin
					d.src = {8{a[7:0]}};
					d.lzsrc = a << 24;
				end
				{1'b0, NSEL_16}: begin
					d.src = {4{a[15:0]}};
					d.lzsrc = a << 16;
				end
				{1'b1, NSEL_8}: begin
					d.src = {{9{a[6:0]}}, a[6]};
					d.lzsrc = a << 25;
				end
				{1'b1, NSEL_16}: begin
					d.src = {{4{a[14:0]}}, a[14:11]};
					d.lzsrc = a << 17;
				end
				{1'b1, NSEL_32}: begin
					d.src = {{2{a[30:0]}}, a[30:29]};
					d.lzsrc = a << 1;
				end
				default: begin
					d.src = {2{a}};
					d.lzsrc = a;
				end
			endcase
		end else begin
			d.src = {a, 32'd0};
			d.lzsrc = a;
			d.ebase = 8'd159 - {2'd0, sh} - 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fnic_shift.sv =====
// Second stage: exponent shift of the scaled product with capping and half-bit
// extraction, and normalization for the integer-to-single path. Depends on fnic_pkg.
`default_nettype none

module fnic_shift (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire fnic_pkg::s1_t st_s1,
	output fnic_pkg::s2_t      st_s2
);
	import fnic_pkg::*;

	s2_t         d;
	logic [96:0] wide;
	logic [55:0] rsh;
	logic [55:0] hsh;
	logic [7:0]  k;
	logic [5:0]  lz;
	logic [63:0] norm;

	always_comb begin
		d = '0;
		d.kind = st_s1.kind;
		d.is_snorm = st_s1.is_snorm;
		d.neg = st_s1.neg;
		d.nan = st_s1.nan;
		d.nsel = st_s1.nsel;
		d.sign = st_s1.sign;
		d.one = st_s1.one;
		d.zero = st_s1.zero;
		wide = {41'd0, st_s1.prod} << st_s1.expo[5:0];
		k = 8'd0 - st_s1.expo[7:0];
		rsh = st_s1.prod >> k[5:0];
		hsh = st_s1.prod >> (k[5:0] - 6'd1);
		if (st_s1.inf) begin
			d.ip = CAP_MAG;
		end else if (st_s1.prod == 56'd0) begin
			d.ip = '0;
		end else if (!st_s1.expo[8]) begin
			if (st_s1.expo >= 9'sd41 || wide >= 97'(CAP_MAG)) begin
				d.ip = CAP_MAG;
			end else begin
				d.ip = wide[40:0];
			end
		end else if (k >= 8'd64) begin
			d.ip = '0;
		end else begin
			d.ip = (rsh >= 56'(CAP_MAG)) ? CAP_MAG : rsh[40:0];
			d.half = hsh[0];
		end

		lz = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (st_s1.lzsrc[i]) begin
				lz = 6'(31 - i);
			end
		end
		norm = st_s1.src << lz[4:0];
		d.nsig = norm[63:39];
		d.nsticky = st_s1.sign ? (norm[38:0] != 39'd0) : 1'b1;
		d.nexp = st_s1.ebase - {2'd0, lz};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fnic_pack.sv =====
// Third stage: bias, clamp and saturation flag for float-to-integer, rounding
// and packing for integer-to-single, into the output register. Depends on fnic_pkg.
`default_nettype none

module fnic_pack (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          round_bias,
	input  wire fnic_pkg::s2_t st_s2,
	output logic        [31:0] result,
	output logic               saturated
);
	import fnic_pkg::*;

	logic [31:0] res;
	logic        sat;
	logic [41:0] mag;
	logic [31:0] lp;
	logic [31:0] ln;
	logic        up;
	logic [24:0] s25;
	logic [7:0]  ex;

	always_comb begin
		res = 32'd0;
		sat = 1'b0;
		lp = lim_pos(st_s2.is_snorm, st_s2.nsel);
		ln = lim_neg(st_s2.nsel);
		mag = 42'(st_s2.ip) + 42'(round_bias & st_s2.half);
		up = st_s2.nsig[0] && (st_s2.nsticky || st_s2.nsig[1]);
		s25 = {1'b0, st_s2.nsig[24:1]} + 25'(up);
		ex = s25[24] ? (st_s2.nexp + 8'd1) : st_s2.nexp;
		case (st_s2.kind)
			KIND_F2N: begin
				if (st_s2.nan) begin
					res = 32'd0;
				end else if (!st_s2.neg) begin
					if (mag > 42'(lp)) begin
						sat = 1'b1;
						res = lp;
					end else begin
						res = mag[31:0];
					end
				end else if (st_s2.is_snorm) begin
					if (mag > 42'(ln)) begin
						sat = 1'b1;
						res = 32'd0 - ln;
					end else begin
						res = 32'd0 - mag[31:0];
					end
				end else begin
					sat = round_bias ? (mag >= 42'd2) : (st_s2.ip != 41'd0);
				end
			end
			KIND_N2F: begin
				if (st_s2.zero) begin
					res = 32'd0;
				end else if (st_s2.one) begin
					res = ONE_SINGLE;
				end else begin
					res = {st_s2.sign, ex, s25[24] ? 23'd0 : s25[22:0]};
				end
			end
			default: begin
				res = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res;
			saturated <= sat;
		end
	end

endmodule

`default_nettype wire

// ===== sv/float_norm_int_converter_core.sv =====
// Float to UNORM/SNORM and back, three-stage pipeline plus the APB bias register.
// Instantiates fnic_decode, fnic_shift and fnic_pack; depends on fnic_pkg.
// Each beat passes the stage-one, stage-two and output registers; one beat per cycle while out_ready holds.
// Each stage advances when it is empty or its successor advances, so bubbles collapse.
// Reset clears the stage valid bits and sets the round-bias register bias_q to 1.
`default_nettype none

module float_norm_int_converter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  command,
	input  wire logic [31:0] operand,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] result,
	output logic             saturated
);
	import fnic_pkg::*;

	logic  bias_q;
	logic  v_s1;
	logic  v_s2;
	logic  en1;
	logic  en2;
	logic  en3;
	s1_t   st_s1;
	s2_t   st_s2;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROUND_BIAS) ? {31'd0, bias_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_ROUND_BIAS) begin
			bias_q <= pwdata[0];
		end
	end

	assign en3 = !out_valid || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				out_valid <= v_s2;
			end
		end
	end

	fnic_decode u_decode (
		.clk(clk),
		.en(en1 && in_valid),
		.command(command),
		.operand(operand),
		.st_s1(st_s1)
	);

	fnic_shift u_shift (
		.clk(clk),
		.en(en2 && v_s1),
		.st_s1(st_s1),
		.st_s2(st_s2)
	);

	fnic_pack u_pack (
		.clk(clk),
		.en(en3 && v_s2),
		.round_bias(bias_q),
		.st_s2(st_s2),
		.result(result),
		.saturated(saturated)
	);

`ifndef ASSERT_OFF
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && out_valid && !out_ready))
		else $error("input stalled while the pipeline has room");
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat did not reach stage one");
	a_s3_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3) |=> out_valid)
		else $error("stage two beat lost on the way to the output");
`endif

endmodule

`default_nettype wire

// ===== test/tb_float_norm_int_converter_core.sv =====
// Self-checking testbench for float_norm_int_converter_core: directed table plus random beats.
// Predicts each conversion with an exact integer model; depends on fnic_pkg and the core RTL.
`default_nettype none

module tb_float_norm_int_converter_core;
	import fnic_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [3:0]  command;
	logic [31:0] operand;
	logic        out_valid, out_ready;
	logic [31:0] result;
	logic        saturated;

	float_norm_int_converter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .operand(operand),
		.out_valid(out_valid), .out_ready(out_ready), .result(result), .saturated(saturated)
	);

	typedef struct packed {
		logic [31:0] value;
		logic        clamped;
	} conv_t;

	typedef struct {
		logic [3:0]  cmd;
		logic [31:0] opnd;
		logic        known;
		logic [31:0] value;
		logic        clamped;
	} row_t;

	conv_t  pending_q[$];
	logic   bias_en;
	int     mismatches;
	bit     quiet;
	bit     feeding;

	function automatic int nbits(logic [63:0] v);
		int k;
		k = 0;
		while (v != 0) begin
			k++;
			v = v >> 1;
		end
		return k;
	endfunction

	function automatic logic [31:0] div_to_single(logic sgn, logic [63:0] a, logic [63:0] d);
		int          s;
		logic [63:0] num, q, r;
		if (a == 0 || d == 0)
			return 32'd0;
		s = 23 + nbits(d) - nbits(a);
		num = a << s;
		q = num / d;
		if (q < 64'h80_0000) begin
			s++;
			num = num << 1;
			q = num / d;
		end
		r = num % d;
		if (2 * r > d || (2 * r == d && q[0]))
			q++;
		if (q >= 64'h100_0000) begin
			q = q >> 1;
			s--;
		end
		return {sgn, 8'(150 - s), q[22:0]};
	endfunction

	function automatic conv_t to_norm(logic snorm, int n, logic [31:0] bits);
		conv_t       o;
		logic [7:0]  ef;
		logic [22:0] fr;
		logic        neg, half;
		logic [63:0] lpos, lneg, ip, mag, m, p;
		int          e, k;
		ef = bits[30:23];
		fr = bits[22:0];
		neg = bits[31] && !(ef == 0 && fr == 0);
		lneg = 64'd1 << (n - 1);
		lpos = snorm ? lneg - 1 : (64'd1 << n) - 1;
		half = 0;
		o = '0;
		if (ef == 8'hFF) begin
			if (fr != 0)
				return o;
			ip = 64'(CAP_MAG);
		end else begin
			m = (ef != 0) ? {40'd0, 1'b1, fr} : {41'd0, fr};
			e = (ef != 0) ? int'(ef) - 150 : -149;
			p = m * ((neg && snorm) ? lneg : lpos);
			if (p == 0)
				ip = 0;
			else if (e >= 0) begin
				if (e >= 41 || p > (64'(CAP_MAG) >> e))
					ip = 64'(CAP_MAG);
				else
					ip = p << e;
			end else begin
				k = -e;
				if (k >= 64)
					ip = 0;
				else begin
					ip = p >> k;
					half = p[k - 1];
				end
			end
		end
		if (!neg || snorm) begin
			mag = ip + (bias_en & half);
			if (!neg && mag > lpos) begin
				o.clamped = 1;
				mag = lpos;
			end
			if (neg && mag > lneg) begin
				o.clamped = 1;
				mag = lneg;
			end
			o.value = neg ? 32'(64'd0 - mag) : mag[31:0];
			return o;
		end
		o.clamped = bias_en ? (ip + half >= 2) : (ip >= 1);
		return o;
	endfunction

	function automatic conv_t convert(logic [3:0] cmd, logic [31:0] opnd);
		conv_t       o;
		int          n;
		logic [63:0] mask, v, h;
		o = '0;
		n = (cmd % 3 == 0) ? 8 : ((cmd % 3 == 1) ? 16 : 32);
		mask = (64'd1 << n) - 1;
		v = {32'd0, opnd} & mask;
		h = 64'd1 << (n - 1);
		if (cmd <= CMD_F2U32)
			o = to_norm(0, n, opnd);
		else if (cmd <= CMD_F2S32)
			o = to_norm(1, n, opnd);
		else if (cmd <= CMD_U2F32)
			o.value = div_to_single(0, v, mask);
		else if (cmd <= CMD_S2F32)
			o.value = (v & h) ? div_to_single(1, mask + 1 - v, h) : div_to_single(0, v, h - 1);
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("FAIL float_norm_int_converter_core");
		$finish;
	end

	// Output side: random stall bursts, compare every beat against the oldest prediction.
	initial begin
		int    gap;
		conv_t exp_r;
		out_ready <= 0;
		mismatches = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat result=%h sat=%b", result, saturated);
				end else begin
					exp_r = pending_q.pop_front();
					if (result !== exp_r.value || saturated !== exp_r.clamped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h/%b got %h/%b", exp_r.value,
								exp_r.clamped, result, saturated);
					end
				end
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 0;
				repeat (gap) @(posedge clk);
				if (out_valid && out_ready) begin
				end
				out_ready <= 1;
			end else
				out_ready <= 1;
		end
	end

	task automatic apb_write(logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(4 * REG_ROUND_BIAS);
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		bias_en = data[0];
	endtask

	task automatic drain();
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send(logic [3:0] cmd, logic [31:0] opnd, bit may_idle);
		if (may_idle && !quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		operand <= opnd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_q.push_back(convert(cmd, opnd));
	endtask

	function automatic logic [31:0] rand_operand(logic [3:0] cmd);
		logic [31:0] r;
		r = $urandom;
		if (cmd <= CMD_F2S32) begin
			case ($urandom_range(0, 5))
				0: r[30:23] = 8'd127 + 8'($urandom_range(0, 2)) - 8'd1;
				1: r[30:23] = 8'($urandom_range(100, 160));
				2: r[30:23] = 8'hFF;
				3: r[30:23] = 8'd0;
				default: ;
			endcase
		end
		return r;
	endfunction

	row_t dir_rows[] = '{
		'{CMD_F2U8,  32'h3F80_0000, 1, 32'h0000_00FF, 0},
		'{CMD_F2U8,  32'h7FC0_0000, 1, 32'h0000_0000, 0},
		'{CMD_F2U16, 32'h7F80_0000, 1, 32'h0000_FFFF, 1},
		'{CMD_F2U32, 32'hFF80_0000, 1, 32'h0000_0000, 1},
		'{CMD_F2U8,  32'h8000_0000, 1, 32'h0000_0000, 0},
		'{CMD_F2S8,  32'hBF80_0000, 1, 32'hFFFF_FF80, 0},
		'{CMD_F2S16, 32'h4000_0000, 1, 32'h0000_7FFF, 1},
		'{CMD_F2S32, 32'hFF80_0000, 1, 32'h8000_0000, 1},
		'{CMD_F2S8,  32'h3F00_0000, 0, 0, 0},
		'{CMD_F2U32, 32'h3F80_0000, 0, 0, 0},
		'{CMD_F2U8,  32'hBB00_0000, 0, 0, 0},
		'{CMD_F2U16, 32'h0000_0001, 0, 0, 0},
		'{CMD_U2F8,  32'hFFFF_FFFF, 1, 32'h3F80_0000, 0},
		'{CMD_U2F16, 32'h0000_0000, 1, 32'h0000_0000, 0},
		'{CMD_U2F32, 32'h0000_0001, 0, 0, 0},
		'{CMD_S2F8,  32'h0000_0080, 1, 32'hBF80_0000, 0},
		'{CMD_S2F16, 32'h0000_7FFF, 1, 32'h3F80_0000, 0},
		'{CMD_S2F32, 32'h8000_0000, 1, 32'hBF80_0000, 0},
		'{CMD_S2F8,  32'hFFFF_FF81, 0, 0, 0},
		'{CMD_S2F32, 32'h0000_0001, 0, 0, 0},
		'{4'd12,     32'h3F80_0000, 1, 32'h0000_0000, 0},
		'{4'd15,     32'hFFFF_FFFF, 1, 32'h0000_0000, 0}
	};

	initial begin
		logic [3:0] c;
		conv_t      p;
		arst_n <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 0;
		command <= '0;
		operand <= '0;
		quiet = 0;
		bias_en = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send(dir_rows[i].cmd, dir_rows[i].opnd, 0);
			if (dir_rows[i].known) begin
				p.value = dir_rows[i].value;
				p.clamped = dir_rows[i].clamped;
				pending_q[pending_q.size() - 1] = p;
			end
		end
		in_valid <= 0;
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			apb_write((ph == 3) ? 32'hFFFF_FFFF : {31'd0, ph[0]});
			if (ph == 0)
				foreach (dir_rows[i])
					send(dir_rows[i].cmd, dir_rows[i].opnd, 0);
			for (int i = 0; i < 420; i++) begin
				quiet = (ph == 3 && i > 300);
				c = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(12, 15))
					: 4'($urandom_range(0, 11));
				send(c, rand_operand(c), 1);
				if (ph == 1 && i == 200) begin
					in_valid <= 0;
					drain();
				end
			end
			in_valid <= 0;
			drain();
		end
		if (mismatches == 0)
			$display("PASS float_norm_int_converter_core");
		else
			$display("FAIL float_norm_int_converter_core");
		$finish;
	end

endmodule

`default_nettype wire
